// ===== sv/fxalu_pkg.sv =====
// Package with the opcode set, widths and shared types of the fixed-point ALU.
package fxalu_pkg;

  localparam int FracBits  = 8;
  localparam int DataWidth = 32;
  localparam int QuoWidth  = DataWidth + FracBits;
  localparam int DivStages = QuoWidth;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_INC  = 4'd4,
    OP_DEC  = 4'd5,
    OP_MIN  = 4'd6,
    OP_MAX  = 4'd7,
    OP_I2F  = 4'd8,
    OP_F2I  = 4'd9
  } op_t;

  // Everything that rides alongside an item through the long division pipe.
  typedef struct packed {
    logic                        valid;
    logic [3:0]                  op;
    logic [DataWidth-1:0]        fast;
    logic                        less;
    logic                        equal;
    logic                        greater;
    logic                        div_zero;
    logic                        neg;
  } side_t;

endpackage

// ===== sv/fixed_point_q24_8_alu_core.sv =====
// Top level of the pipelined signed Q24.8 fixed-point ALU.
//
// Usage: drive op, operand_a and operand_b and raise start. A request is
// taken at every rising edge where start is high and busy is low. busy is
// tied low because the pipeline never stalls, so one request can enter in
// every cycle.
// Every request produces exactly one result on result, a_less, a_equal,
// a_greater and status, marked by done for one cycle. The receiver cannot
// hold results off, and none is needed: results leave in request order.
// Every opcode takes the same path: one input register stage,
// one stage that forms the product or the divider operands, forty stages of
// the restoring divider (one quotient bit each, 40-bit dividend), and one
// output register. Non-divide operations ride the divider pipe alongside
// so that order is kept. The multiplier sits between its own registers.
// Throughput is one request per clock.
// Reset clears every valid bit, so no result appears after reset until a
// new request has been accepted. Division by zero yields zero and status 1.
module fixed_point_q24_8_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic        done,
  output logic signed [31:0] result,
  output logic        a_less,
  output logic        a_equal,
  output logic        a_greater,
  output logic        status
);

  localparam int DW = fxalu_pkg::DataWidth;
  localparam int FB = fxalu_pkg::FracBits;
  localparam int QW = fxalu_pkg::QuoWidth;

  assign busy = 1'b0;

  // Stage 1: capture the request.
  logic              s1_valid;
  logic [3:0]        s1_op;
  logic signed [DW-1:0] s1_a;
  logic signed [DW-1:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_op <= op;
    s1_a  <= operand_a;
    s1_b  <= operand_b;
  end

  // Stage 2: cheap operations, the compare flags, the product and the
  // magnitude operands of the divider.
  logic [DW-1:0]     fast_val;
  logic              lt;
  logic              gt;
  logic [DW-1:0]     abs_a;
  logic [DW-1:0]     abs_b;

  assign lt    = s1_a < s1_b;
  assign gt    = s1_a > s1_b;
  assign abs_a = s1_a[DW-1] ? DW'(-s1_a) : s1_a;
  assign abs_b = s1_b[DW-1] ? DW'(-s1_b) : s1_b;

  always_comb begin
    unique case (s1_op)
      fxalu_pkg::OP_ADD: fast_val = s1_a + s1_b;
      fxalu_pkg::OP_SUB: fast_val = s1_a - s1_b;
      fxalu_pkg::OP_INC: fast_val = s1_a + DW'(1);
      fxalu_pkg::OP_DEC: fast_val = s1_a - DW'(1);
      fxalu_pkg::OP_MIN: fast_val = lt ? s1_a : s1_b;
      fxalu_pkg::OP_MAX: fast_val = gt ? s1_a : s1_b;
      fxalu_pkg::OP_I2F: fast_val = s1_a << FB;
      fxalu_pkg::OP_F2I: fast_val = DW'(s1_a >>> FB);
      default:           fast_val = '0;
    endcase
  end

  fxalu_pkg::side_t         s2_side;
  logic signed [2*DW-1:0]   s2_prod;
  logic [QW-1:0]            s2_num;
  logic [DW-1:0]            s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else begin
      s2_side.valid <= s1_valid;
    end
    s2_side.op       <= s1_op;
    s2_side.fast     <= fast_val;
    s2_side.less     <= lt;
    s2_side.equal    <= (s1_a == s1_b);
    s2_side.greater  <= gt;
    s2_side.div_zero <= (s1_b == '0);
    s2_side.neg      <= s1_a[DW-1] ^ s1_b[DW-1];
    s2_prod          <= s1_a * s1_b;
    s2_num           <= {abs_a, FB'(0)};
    s2_den           <= abs_b;
  end

  // The product is folded into the fast value on entry to the divider pipe.
  fxalu_pkg::side_t div_side_in;
  always_comb begin
    div_side_in = s2_side;
    if (s2_side.op == fxalu_pkg::OP_MUL) begin
      div_side_in.fast = s2_prod[DW+FB-1:FB];
    end
  end

  fxalu_pkg::side_t div_side_out;
  logic [QW-1:0]    quo;

  fxalu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .side_in  (div_side_in),
    .dividend (s2_num),
    .divisor  (s2_den),
    .side_out (div_side_out),
    .quotient (quo)
  );

  // Output stage: pick the quotient for divides, apply the sign.
  logic [DW-1:0] quo_signed;
  assign quo_signed = div_side_out.neg ? DW'(-quo) : quo[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_side_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_less    <= div_side_out.less;
    a_equal   <= div_side_out.equal;
    a_greater <= div_side_out.greater;
    if (div_side_out.op == fxalu_pkg::OP_DIV) begin
      result <= div_side_out.div_zero ? '0 : quo_signed;
      status <= div_side_out.div_zero;
    end else begin
      result <= div_side_out.fast;
      status <= 1'b0;
    end
  end

endmodule

// ===== sv/fxalu_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module fxalu_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fxalu_pkg::side_t                      side_in,
  input  logic [fxalu_pkg::QuoWidth-1:0]        dividend,
  input  logic [fxalu_pkg::DataWidth-1:0]       divisor,
  output fxalu_pkg::side_t                      side_out,
  output logic [fxalu_pkg::QuoWidth-1:0]        quotient
);

  localparam int QW = fxalu_pkg::QuoWidth;
  localparam int DW = fxalu_pkg::DataWidth;
  localparam int NS = fxalu_pkg::DivStages;

  fxalu_pkg::side_t side [NS+1];
  logic [QW-1:0]    quo  [NS+1];
  logic [DW:0]      rem  [NS+1];
  logic [DW-1:0]    dvs  [NS+1];

  assign side[0] = side_in;
  assign quo[0]  = dividend;
  assign rem[0]  = '0;
  assign dvs[0]  = divisor;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    assign trial = {rem[s][DW-1:0], quo[s][QW-1]};
    assign diff  = trial - {1'b0, dvs[s]};

    always_ff @(posedge clk) begin
      side[s+1] <= side[s];
      if (rst) begin
        side[s+1].valid <= 1'b0;
      end
      dvs[s+1] <= dvs[s];
      if (!diff[DW]) begin
        rem[s+1] <= diff;
        quo[s+1] <= {quo[s][QW-2:0], 1'b1};
      end else begin
        rem[s+1] <= trial;
        quo[s+1] <= {quo[s][QW-2:0], 1'b0};
      end
    end
  end

  assign side_out = side[NS];
  assign quotient = quo[NS];

endmodule

// ===== sv/fxalu_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
module fxalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] result,
  input logic        a_less,
  input logic        a_equal,
  input logic        a_greater,
  input logic        status
);

  // Exactly one relation holds between the operands of each result.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  // A divide-by-zero result is always zero.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (result == '0))
    else $error("nonzero result with error status");

  // The pipeline never holds a request off.
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  // No result can appear shortly after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind fixed_point_q24_8_alu_core fxalu_checker u_fxalu_checker (.*);
